[src/nsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants, types and character helpers for the sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

   localparam int POS_W          = 8;
   localparam int LINE_BYTES_DEF = 128;
   localparam int TOKEN_LEN      = 7;

   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_RMC   = 2'd1,
      KIND_GGA   = 2'd2
   } kind_type;

   typedef struct packed {
      logic       sentence_ok;
      kind_type   sentence_kind;
      logic [7:0] computed_xor;
      logic [7:0] line_length;
      logic [7:0] field_count;
   } result_type;

   // Expected character of "$GPRMC," at a token position.
   function automatic logic [7:0] rmc_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = CHAR_DOLLAR;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         default: c = CHAR_COMMA;
      endcase
      return c;
   endfunction

   // Expected character of "$GPGGA," at a token position.
   function automatic logic [7:0] gga_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = CHAR_DOLLAR;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h47;
         3'd4: c = 8'h47;
         3'd5: c = 8'h41;
         default: c = CHAR_COMMA;
      endcase
      return c;
   endfunction

   // Value of an uppercase hex digit; bit 4 set when not a digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      priority if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, c[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

[src/nmea_sentence_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// Frames received bytes into lines and checks each line's NMEA checksum.
// ----------------------------------------------------------------------------
// Path: a newline byte taken into the input register moves on into the result
// register, which drives the result ports.
// Throughput: one byte per cycle; a newline waits only while the result
// register holds an untaken result.
// Reset: synchronous; clears both registers' valid flags and the line state.
module nmea_sentence_checker #(
   parameter int LINE_BYTES = nsc_pkg::LINE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sentence_ok,
   output logic [1:0] rsp_sentence_kind,
   output logic [7:0] rsp_computed_xor,
   output logic [7:0] rsp_line_length,
   output logic [7:0] rsp_field_count
);
   import nsc_pkg::*;

   logic       in_valid;
   logic [7:0] in_byte;
   logic       is_newline;
   logic       out_free;
   logic       advance;
   result_type line_result;
   result_type rsp_data;

   assign advance = in_valid && (!is_newline || out_free);

   nsc_input_reg u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .req_stall   (req_stall),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   nsc_line_tracker #(
      .LINE_BYTES (LINE_BYTES)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte),
      .is_newline (is_newline),
      .result     (line_result)
   );

   nsc_result_reg u_result (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && is_newline),
      .load_data (line_result),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_sentence_ok   = rsp_data.sentence_ok;
   assign rsp_sentence_kind = rsp_data.sentence_kind;
   assign rsp_computed_xor  = rsp_data.computed_xor;
   assign rsp_line_length   = rsp_data.line_length;
   assign rsp_field_count   = rsp_data.field_count;

   a_stall_only_on_full_output: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && in_valid && is_newline))
      else $error("request stalled without a blocked result");

   a_kind_needs_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sentence_kind != KIND_OTHER) |->
         (rsp_sentence_ok && rsp_line_length >= 8'd8 && rsp_field_count >= 8'd2))
      else $error("sentence kind reported for an unqualified line");

   a_ok_needs_length: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sentence_ok) |-> (rsp_line_length >= 8'd6))
      else $error("short line reported valid");

   a_result_from_newline: assert property (
      @(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid)) |-> $past(advance && is_newline))
      else $error("result appeared without a newline");

endmodule
`default_nettype wire

[src/nsc_input_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_input_reg
// Input register for received bytes; holds its byte while the next stage
// cannot take it.
// ----------------------------------------------------------------------------
module nsc_input_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       req_stall,
   output logic       in_valid,
   output logic [7:0] in_byte
);
   import nsc_pkg::*;

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign req_stall = valid_ff && !advance;
   assign in_valid  = valid_ff;
   assign in_byte   = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule
`default_nettype wire

[src/nsc_line_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_line_tracker
// Per-line state: position, checksum window, token match and comma count.
// Forms the result for a newline byte.
// ----------------------------------------------------------------------------
module nsc_line_tracker #(
   parameter int LINE_BYTES = nsc_pkg::LINE_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   output logic                 is_newline,
   output nsc_pkg::result_type  result
);
   import nsc_pkg::*;

   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [7:0]       xor_ff,    xor_in;
   logic [7:0]       recent_ff [4];
   logic [7:0]       recent_in [4];
   logic             dollar_ff, dollar_in;
   logic             rmc_ff,    rmc_in;
   logic             gga_ff,    gga_in;
   logic [7:0]       comma_ff,  comma_in;

   logic [POS_W:0]   pos_next;
   logic [4:0]       hi_v;
   logic [4:0]       lo_v;
   logic [7:0]       x;
   logic             ok;

   assign is_newline = (in_byte == CHAR_NEWLINE);
   assign pos_next   = {1'b0, pos_ff} + {{POS_W{1'b0}}, 1'b1};

   always_comb begin
      hi_v = hex_value(recent_ff[2]);
      lo_v = hex_value(recent_ff[1]);
      x    = (pos_ff >= POS_W'(5)) ? xor_ff : 8'h00;
      ok   = (pos_ff >= POS_W'(5)) && dollar_ff && (recent_ff[3] == CHAR_STAR)
             && !hi_v[4] && !lo_v[4] && ({hi_v[3:0], lo_v[3:0]} == x);

      result.sentence_ok   = ok;
      result.computed_xor  = x;
      result.line_length   = pos_next[7:0];
      result.field_count   = comma_ff + 8'd1;
      result.sentence_kind = KIND_OTHER;
      if (ok && pos_ff >= POS_W'(7)) begin
         priority if (rmc_ff) begin
            result.sentence_kind = KIND_RMC;
         end else if (gga_ff) begin
            result.sentence_kind = KIND_GGA;
         end else begin
            result.sentence_kind = KIND_OTHER;
         end
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      xor_in       = xor_ff;
      recent_in    = recent_ff;
      dollar_in    = dollar_ff;
      rmc_in       = rmc_ff;
      gga_in       = gga_ff;
      comma_in     = comma_ff;
      if (step) begin
         if (is_newline || pos_next >= (POS_W+1)'(LINE_BYTES)) begin
            pos_in    = '0;
            xor_in    = '0;
            recent_in = '{default: 8'h00};
            dollar_in = 1'b0;
            rmc_in    = 1'b1;
            gga_in    = 1'b1;
            comma_in  = '0;
         end else begin
            pos_in = pos_next[POS_W-1:0];
            if (pos_ff == '0) begin
               dollar_in = (in_byte == CHAR_DOLLAR);
            end
            if (pos_ff < POS_W'(TOKEN_LEN)) begin
               if (in_byte != rmc_char(pos_ff[2:0])) rmc_in = 1'b0;
               if (in_byte != gga_char(pos_ff[2:0])) gga_in = 1'b0;
            end
            if (in_byte == CHAR_COMMA) begin
               comma_in = comma_ff + 8'd1;
            end
            if (pos_ff >= POS_W'(5)) begin
               xor_in = xor_ff ^ recent_ff[3];
            end
            recent_in[3] = recent_ff[2];
            recent_in[2] = recent_ff[1];
            recent_in[1] = recent_ff[0];
            recent_in[0] = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         xor_ff    <= '0;
         recent_ff <= '{default: 8'h00};
         dollar_ff <= 1'b0;
         rmc_ff    <= 1'b1;
         gga_ff    <= 1'b1;
         comma_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         xor_ff    <= xor_in;
         recent_ff <= recent_in;
         dollar_ff <= dollar_in;
         rmc_ff    <= rmc_in;
         gga_ff    <= gga_in;
         comma_ff  <= comma_in;
      end
   end

endmodule
`default_nettype wire

[src/nsc_result_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_result_reg
// Result register; holds a line result until the consumer takes it.
// ----------------------------------------------------------------------------
module nsc_result_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  nsc_pkg::result_type load_data,
   input  logic                rsp_stall,
   output logic                free,
   output logic                rsp_valid,
   output nsc_pkg::result_type rsp_data
);
   import nsc_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         data_ff <= load_data;
      end
   end

endmodule
`default_nettype wire

[test/tb_nmea_sentence_checker.sv]
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checker
// Feeds framed NMEA lines, noise and overlong lines to the sentence checker
// one byte per request, predicts each line's result in the bench and
// compares every returned result field by field under random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;
   import nsc_pkg::*;

   localparam int LINE_LIMIT     = LINE_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TARGET_BYTES   = 1650;
   localparam int MAX_REPORTS    = 10;
   localparam int BODY_MAX       = LINE_LIMIT - 6;

   localparam logic [55:0] RMC_TOKEN = "$GPRMC,";
   localparam logic [55:0] GGA_TOKEN = "$GPGGA,";
   localparam logic [7:0]  CHAR_CR   = 8'h0D;

   typedef enum int {
      FAULT_NONE,
      FAULT_CHECKSUM,
      FAULT_LOWER_HEX,
      FAULT_NO_DOLLAR,
      FAULT_NO_STAR,
      FAULT_BAD_HEX,
      FAULT_ODD_CR
   } fault_type;

   typedef enum int {
      TOKEN_RMC,
      TOKEN_GGA,
      TOKEN_OTHER
   } token_type;

   typedef struct {
      logic [7:0] rx_byte;
      bit         wait_drain;
   } byte_request_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic       rsp_sentence_ok;
   logic [1:0] rsp_sentence_kind;
   logic [7:0] rsp_computed_xor;
   logic [7:0] rsp_line_length;
   logic [7:0] rsp_field_count;

   byte_request_type pending_requests[$];
   result_type       line_results[$];
   result_type       want;
   logic [7:0]       scratch_line[$];

   logic [7:0] line_pos;
   logic [7:0] xor_acc;
   logic [7:0] comma_total;
   logic [7:0] window [4];
   bit         starts_dollar;
   bit         rmc_live;
   bit         gga_live;

   int bytes_sent     = 0;
   int total_requests = 1;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   bit timed_out      = 1'b0;

   nmea_sentence_checker #(
      .LINE_BYTES(LINE_LIMIT)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sentence_ok   (rsp_sentence_ok),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_computed_xor  (rsp_computed_xor),
      .rsp_line_length   (rsp_line_length),
      .rsp_field_count   (rsp_field_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic int idle_phase();
      if (bytes_sent < total_requests / 3) begin
         return 0;
      end else if (bytes_sent < (2 * total_requests) / 3) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic int sender_idle_pct();
      int phase;
      phase = idle_phase();
      return (phase == 0) ? 35 : (phase == 1) ? 50 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      int phase;
      phase = idle_phase();
      return (phase == 0) ? 50 : (phase == 1) ? 35 : 0;
   endfunction

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - int'(8'h30);
      end else if (c >= "A" && c <= "F") begin
         return int'(c) - int'(8'h41) + 10;
      end
      return 16;
   endfunction

   task automatic clear_line_tracker();
      line_pos      = 8'd0;
      xor_acc       = 8'd0;
      comma_total   = 8'd0;
      window[0]     = 8'd0;
      window[1]     = 8'd0;
      window[2]     = 8'd0;
      window[3]     = 8'd0;
      starts_dollar = 1'b0;
      rmc_live      = 1'b1;
      gga_live      = 1'b1;
   endtask

   task automatic track_nmea_byte(input logic [7:0] b);
      result_type r;
      int         hi;
      int         lo;
      int         p;
      p = int'(line_pos);
      if (b == CHAR_NEWLINE) begin
         hi = hex_digit_value(window[2]);
         lo = hex_digit_value(window[1]);
         r.computed_xor  = (p >= 5) ? xor_acc : 8'h00;
         r.sentence_ok   = (p >= 5) && starts_dollar && (window[3] == CHAR_STAR)
                           && (hi < 16) && (lo < 16)
                           && ((hi * 16 + lo) == int'(r.computed_xor));
         r.sentence_kind = KIND_OTHER;
         if (r.sentence_ok && p >= 7) begin
            if (rmc_live) begin
               r.sentence_kind = KIND_RMC;
            end else if (gga_live) begin
               r.sentence_kind = KIND_GGA;
            end
         end
         r.line_length = line_pos + 8'd1;
         r.field_count = comma_total + 8'd1;
         line_results.push_back(r);
         clear_line_tracker();
      end else begin
         if (p == 0) begin
            starts_dollar = (b == CHAR_DOLLAR);
         end
         if (p < 7) begin
            if (b != RMC_TOKEN[55 - 8 * p -: 8]) begin
               rmc_live = 1'b0;
            end
            if (b != GGA_TOKEN[55 - 8 * p -: 8]) begin
               gga_live = 1'b0;
            end
         end
         if (b == CHAR_COMMA) begin
            comma_total = comma_total + 8'd1;
         end
         if (p >= 5) begin
            xor_acc = xor_acc ^ window[3];
         end
         window[3] = window[2];
         window[2] = window[1];
         window[1] = window[0];
         window[0] = b;
         if (p + 1 >= LINE_LIMIT) begin
            clear_line_tracker();
         end else begin
            line_pos = line_pos + 8'd1;
         end
      end
   endtask

   function automatic logic [7:0] content_byte();
      logic [7:0] b;
      if ($urandom_range(7, 0) == 0) begin
         b = 8'($urandom);
         if (b == CHAR_NEWLINE) begin
            b = 8'h0B;
         end
      end else begin
         b = 8'($urandom_range(126, 32));
      end
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) begin
         return 8'h30 + 8'(n);
      end
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   task automatic queue_line(input logic [7:0] text[$], input bit wait_drain);
      byte_request_type item;
      int               i;
      for (i = 0; i < text.size(); i++) begin
         item.rx_byte    = text[i];
         item.wait_drain = wait_drain && (i == 0);
         pending_requests.push_back(item);
      end
   endtask

   task automatic queue_text(input string s, input bit with_cr, input bit wait_drain);
      logic [7:0] text[$];
      int         i;
      for (i = 0; i < s.len(); i++) begin
         text.push_back(s[i]);
      end
      if (with_cr) begin
         text.push_back(CHAR_CR);
      end
      text.push_back(CHAR_NEWLINE);
      queue_line(text, wait_drain);
   endtask

   task automatic queue_sentence(input token_type tok, input int n_fields, input int body_cap,
                                 input fault_type fault, input bit wait_drain);
      logic [7:0] text[$];
      logic [7:0] body[$];
      logic [7:0] xor_sum;
      logic [7:0] b;
      string      name;
      int         i;
      int         j;
      int         n_chars;
      xor_sum = 8'h00;
      if (tok == TOKEN_OTHER) begin
         n_chars = $urandom_range(6, 1);
         for (i = 0; i < n_chars; i++) begin
            body.push_back(8'($urandom_range(90, 65)));
         end
      end else begin
         name = (tok == TOKEN_RMC) ? "GPRMC" : "GPGGA";
         for (i = 0; i < name.len(); i++) begin
            body.push_back(name[i]);
         end
      end
      for (i = 0; i < n_fields; i++) begin
         if (body.size() < body_cap) begin
            body.push_back(CHAR_COMMA);
         end
         n_chars = $urandom_range(6, 0);
         for (j = 0; j < n_chars; j++) begin
            if (body.size() < body_cap) begin
               body.push_back(content_byte());
            end
         end
      end
      for (i = 0; i < body.size(); i++) begin
         xor_sum = xor_sum ^ body[i];
      end
      if (fault == FAULT_CHECKSUM) begin
         xor_sum = xor_sum ^ 8'($urandom_range(255, 1));
      end
      b = content_byte();
      text.push_back((fault == FAULT_NO_DOLLAR) ? ((b == CHAR_DOLLAR) ? 8'h23 : b)
                                                : CHAR_DOLLAR);
      for (i = 0; i < body.size(); i++) begin
         text.push_back(body[i]);
      end
      b = content_byte();
      text.push_back((fault == FAULT_NO_STAR) ? ((b == CHAR_STAR) ? 8'h23 : b) : CHAR_STAR);
      text.push_back(hex_char(xor_sum[7:4], fault == FAULT_LOWER_HEX));
      if (fault == FAULT_BAD_HEX) begin
         text.push_back(8'($urandom_range(90, 71)));
      end else begin
         text.push_back(hex_char(xor_sum[3:0], fault == FAULT_LOWER_HEX));
      end
      text.push_back((fault == FAULT_ODD_CR) ? content_byte() : CHAR_CR);
      text.push_back(CHAR_NEWLINE);
      queue_line(text, wait_drain);
   endtask

   task automatic queue_overlong(input int n_bytes, input bit end_line);
      int i;
      scratch_line = {};
      for (i = 0; i < n_bytes; i++) begin
         scratch_line.push_back(content_byte());
      end
      if (end_line) begin
         scratch_line.push_back(CHAR_NEWLINE);
      end
      queue_line(scratch_line, 1'b0);
   endtask

   task automatic build_directed_lines();
      fault_type f;
      queue_text("", 1'b0, 1'b0);
      queue_text("$", 1'b0, 1'b0);
      queue_text("$*0", 1'b1, 1'b0);
      queue_text("$*00", 1'b0, 1'b0);
      queue_text("$*00", 1'b1, 1'b0);
      queue_text("$*01", 1'b1, 1'b0);
      queue_text("$J*4A", 1'b1, 1'b0);
      queue_text("$J*4a", 1'b1, 1'b0);
      queue_sentence(TOKEN_RMC, 0, BODY_MAX, FAULT_NONE, 1'b0);
      queue_sentence(TOKEN_GGA, 0, BODY_MAX, FAULT_NONE, 1'b0);
      queue_sentence(TOKEN_RMC, 4, 60, FAULT_NONE, 1'b1);
      queue_sentence(TOKEN_GGA, 6, 60, FAULT_NONE, 1'b0);
      queue_sentence(TOKEN_OTHER, 3, 40, FAULT_NONE, 1'b0);
      for (f = FAULT_CHECKSUM; f <= FAULT_ODD_CR; f = fault_type'(int'(f) + 1)) begin
         queue_sentence(TOKEN_RMC, 2, 30, f, 1'b0);
      end
      scratch_line = {CHAR_DOLLAR, 8'h00, 8'hFF, CHAR_STAR, 8'h46, 8'h46,
                      CHAR_CR, CHAR_NEWLINE};
      queue_line(scratch_line, 1'b0);
      queue_sentence(TOKEN_GGA, 60, BODY_MAX, FAULT_NONE, 1'b0);
      queue_overlong(LINE_LIMIT, 1'b0);
      queue_text("$*00", 1'b1, 1'b0);
      queue_overlong(LINE_LIMIT + 12, 1'b1);
   endtask

   task automatic build_random_lines();
      int sel;
      int cap;
      int n;
      int i;
      bit drain;
      bit first_line;
      first_line = 1'b1;
      while (pending_requests.size() < TARGET_BYTES) begin
         sel        = $urandom_range(99, 0);
         drain      = first_line || chance(5);
         first_line = 1'b0;
         cap = ($urandom_range(9, 0) == 0) ? $urandom_range(BODY_MAX, 40)
                                            : $urandom_range(40, 0);
         if (sel < 65) begin
            queue_sentence(token_type'($urandom_range(2, 0)), $urandom_range(8, 0), cap,
                           FAULT_NONE, drain);
         end else if (sel < 85) begin
            queue_sentence(token_type'($urandom_range(2, 0)), $urandom_range(8, 0), cap,
                           fault_type'($urandom_range(int'(FAULT_ODD_CR),
                                                      int'(FAULT_CHECKSUM))), drain);
         end else if (sel < 97) begin
            scratch_line = {};
            n = $urandom_range(40, 0);
            for (i = 0; i < n; i++) begin
               scratch_line.push_back((i == 0 && chance(30)) ? CHAR_DOLLAR : content_byte());
            end
            scratch_line.push_back(CHAR_NEWLINE);
            queue_line(scratch_line, drain);
         end else begin
            queue_overlong($urandom_range(LINE_LIMIT + 72, LINE_LIMIT), 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_nmea_byte(req_rx_byte);
            void'(pending_requests.pop_front());
            bytes_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (pending_requests.size() != 0
                      && !(pending_requests[0].wait_drain && line_results.size() != 0)
                      && !chance(sender_idle_pct())) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_requests[0].rx_byte;
         end else begin
            req_valid   <= 1'b0;
            req_rx_byte <= 8'($urandom);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (line_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("unexpected result: ok=%0d kind=%0d xor=%02h len=%0d fields=%0d",
                           rsp_sentence_ok, rsp_sentence_kind, rsp_computed_xor,
                           rsp_line_length, rsp_field_count);
               end
            end else begin
               want = line_results.pop_front();
               if (rsp_sentence_ok !== want.sentence_ok
                   || rsp_sentence_kind !== want.sentence_kind
                   || rsp_computed_xor !== want.computed_xor
                   || rsp_line_length !== want.line_length
                   || rsp_field_count !== want.field_count) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch: expected ok=%0d kind=%0d xor=%02h len=%0d fields=%0d",
                              want.sentence_ok, want.sentence_kind, want.computed_xor,
                              want.line_length, want.field_count);
                     $display("          actual   ok=%0d kind=%0d xor=%02h len=%0d fields=%0d",
                              rsp_sentence_ok, rsp_sentence_kind, rsp_computed_xor,
                              rsp_line_length, rsp_field_count);
                  end
               end
            end
         end
         rsp_stall <= chance(receiver_idle_pct());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_line_tracker();
      build_directed_lines();
      build_random_lines();
      total_requests = pending_requests.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (!timed_out && (pending_requests.size() != 0 || line_results.size() != 0)) begin
         @(posedge clock);
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
         end
      end
      if (timed_out) begin
         $display("== FAIL ==");
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && line_results.size() == 0) begin
            $display("== PASS ==");
         end else begin
            $display("== FAIL ==");
         end
      end
      $finish;
   end

endmodule
